[hdl/assert_macros.svh]
// Assertion macros shared by the rational arithmetic unit modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[hdl/rar_pkg.sv]
// Types and constants of the rational arithmetic unit.
`timescale 1ns / 1ps

package rar_pkg;

  localparam int OPERAND_W = 16;
  localparam int MAG_W     = OPERAND_W;
  localparam int PROD_W    = 2 * OPERAND_W - 1;
  localparam int SUM_W     = 2 * OPERAND_W;
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 31;
  localparam int STATUS_W  = 2;
  localparam int CMD_W     = 2;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_ZERO_DEN = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DIV_ZERO = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]            command;
    logic signed [OPERAND_W-1:0] a_num;
    logic signed [OPERAND_W-1:0] a_den;
    logic signed [OPERAND_W-1:0] b_num;
    logic signed [OPERAND_W-1:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]        res_den;
    logic [STATUS_W-1:0]         status;
  } out_t;

  // Classified job handed from front to back: unreduced magnitudes and result sign.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                neg;
    logic [SUM_W-1:0]    num_mag;
    logic [SUM_W-1:0]    den_mag;
  } job_t;

endpackage

[hdl/rational_arith_reduce_unit.sv]
// Error and zero-numerator requests skip the GCD loop and the division in the back.
// Front: three cross products on one shared multiplier, one add, then a queue push.
// Back: binary GCD loop, then bit-serial division of both values by the GCD.
// The back takes a new job from the queue only once it has finished the last one;
// the front takes a new request only after it has pushed the last one to the queue.
// Reset (rst, synchronous): clears both sequencers, the queue count and the result valid.
`timescale 1ns / 1ps

module rational_arith_reduce_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rar_pkg::in_t  req_data,
  output logic          res_valid,
  input  logic          res_stall,
  output rar_pkg::out_t res_data
);

  logic          push, full, pop, empty;
  rar_pkg::job_t push_data, pop_data;

  rar_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  rar_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  rar_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

[hdl/rar_front.sv]
// Front end: accepts a request, checks errors, forms cross products on one shared multiplier.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rar_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rar_pkg::in_t  req_data,
  output logic          push,
  output rar_pkg::job_t push_data,
  input  logic          full
);

  typedef enum logic [2:0] {F_IDLE, F_MUL0, F_MUL1, F_MUL2, F_SUM, F_PUSH} state_t;

  localparam int W  = rar_pkg::OPERAND_W;
  localparam int MW = rar_pkg::MAG_W;
  localparam int PW = rar_pkg::PROD_W;
  localparam int SW = rar_pkg::SUM_W;

  function automatic logic [MW-1:0] mag_of(input logic [W-1:0] v);
    mag_of = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  state_t state;
  logic [rar_pkg::CMD_W-1:0] cmd;
  logic [MW-1:0] an_mag, ad_mag, bn_mag, bd_mag;
  logic an_neg, ad_neg, bn_neg, bd_neg;
  logic [rar_pkg::STATUS_W-1:0] status;
  logic [PW-1:0] p0_mag, p1_mag, p2_mag;
  logic p0_neg, p1_neg, p2_neg;
  rar_pkg::job_t job;

  logic [MW-1:0] x_mag, y_mag;
  logic x_neg, y_neg;
  logic [2*W-1:0] prod_full;
  logic [PW-1:0] prod_mag;
  logic prod_neg;

  logic [SW-1:0] sa, sb, sum_mag;
  logic sb_neg, sum_neg;

  logic [MW-1:0] in_an, in_ad, in_bn, in_bd;

  assign req_stall = (state != F_IDLE);
  assign push      = (state == F_PUSH);
  assign push_data = job;

  assign in_an = mag_of(req_data.a_num);
  assign in_ad = mag_of(req_data.a_den);
  assign in_bn = mag_of(req_data.b_num);
  assign in_bd = mag_of(req_data.b_den);

  // Operand schedule for the shared multiplier.
  always_comb begin
    x_mag = ad_mag;
    x_neg = ad_neg;
    y_mag = bd_mag;
    y_neg = bd_neg;
    case (state)
      F_MUL0: begin
        x_mag = an_mag;
        x_neg = an_neg;
        y_mag = (cmd == rar_pkg::CMD_MUL) ? bn_mag : bd_mag;
        y_neg = (cmd == rar_pkg::CMD_MUL) ? bn_neg : bd_neg;
      end
      F_MUL1: begin
        x_mag = bn_mag;
        x_neg = bn_neg;
        y_mag = ad_mag;
        y_neg = ad_neg;
      end
      default: begin
        y_mag = (cmd == rar_pkg::CMD_DIV) ? bn_mag : bd_mag;
        y_neg = (cmd == rar_pkg::CMD_DIV) ? bn_neg : bd_neg;
      end
    endcase
  end

  assign prod_full = (2 * W)'(x_mag) * (2 * W)'(y_mag);
  assign prod_mag  = prod_full[PW-1:0];
  assign prod_neg  = (x_neg ^ y_neg) && (prod_mag != '0);

  // Sign-magnitude add or subtract of the two cross products for ADD and SUB; MUL and DIV pass the first product on.
  always_comb begin
    sa     = SW'(p0_mag);
    sb     = SW'(p1_mag);
    sb_neg = p1_neg ^ ((cmd == rar_pkg::CMD_SUB) && (p1_mag != '0));
    if ((cmd == rar_pkg::CMD_ADD) || (cmd == rar_pkg::CMD_SUB)) begin
      if (p0_neg == sb_neg) begin
        sum_mag = sa + sb;
        sum_neg = p0_neg;
      end else if (sa >= sb) begin
        sum_mag = sa - sb;
        sum_neg = p0_neg;
      end else begin
        sum_mag = sb - sa;
        sum_neg = sb_neg;
      end
    end else begin
      sum_mag = sa;
      sum_neg = p0_neg;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (req_valid) begin
            cmd    <= req_data.command;
            an_mag <= in_an;
            ad_mag <= in_ad;
            bn_mag <= in_bn;
            bd_mag <= in_bd;
            an_neg <= req_data.a_num[W-1];
            ad_neg <= req_data.a_den[W-1];
            bn_neg <= req_data.b_num[W-1];
            bd_neg <= req_data.b_den[W-1];
            if ((in_ad == '0) || (in_bd == '0)) begin
              status <= rar_pkg::STAT_ZERO_DEN;
            end else if ((req_data.command == rar_pkg::CMD_DIV) && (in_bn == '0)) begin
              status <= rar_pkg::STAT_DIV_ZERO;
            end else begin
              status <= rar_pkg::STAT_OK;
            end
            state <= F_MUL0;
          end
        end
        F_MUL0: begin
          p0_mag <= prod_mag;
          p0_neg <= prod_neg;
          state  <= F_MUL1;
        end
        F_MUL1: begin
          p1_mag <= prod_mag;
          p1_neg <= prod_neg;
          state  <= F_MUL2;
        end
        F_MUL2: begin
          p2_mag <= prod_mag;
          p2_neg <= prod_neg;
          state  <= F_SUM;
        end
        F_SUM: begin
          job.status  <= status;
          job.neg     <= sum_neg != p2_neg;
          job.num_mag <= sum_mag;
          job.den_mag <= SW'(p2_mag);
          state       <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_front_start, (state == F_IDLE && req_valid) |=> (state == F_MUL0), "front missed a request")

endmodule

[hdl/rar_queue.sv]
// Short job queue between front and back.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rar_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rar_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output rar_pkg::job_t pop_data,
  output logic          empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rar_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic push_ok, pop_ok;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_q_underflow, pop && empty, "pop from empty queue")
  `ASSERT_CLK(a_q_count, count <= CW'(DEPTH), "queue count out of range")
  `ASSERT_CLK(a_q_fill, (push_ok && !pop_ok) |=> (count == $past(count) + 1'b1), "queue fill lost")

endmodule

[hdl/rar_back.sv]
// Back end: binary GCD, bit-serial division by the GCD, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rar_back (
  input  logic          clk,
  input  logic          rst,
  output logic          pop,
  input  rar_pkg::job_t pop_data,
  input  logic          empty,
  output logic          res_valid,
  input  logic          res_stall,
  output rar_pkg::out_t res_data
);

  typedef enum logic [2:0] {B_IDLE, B_GCD, B_SCALE, B_DIV, B_DONE} state_t;

  localparam int SW  = rar_pkg::SUM_W;
  localparam int KW  = $clog2(SW + 1);
  localparam int CW  = $clog2(SW);
  localparam int NXW = (SW + 1 > rar_pkg::RES_NUM_W) ? SW + 1 : rar_pkg::RES_NUM_W;
  localparam int DXW = (SW > rar_pkg::RES_DEN_W) ? SW : rar_pkg::RES_DEN_W;

  state_t state;
  rar_pkg::job_t job;
  logic [SW-1:0] u, v, g;
  logic [KW-1:0] k;
  logic [SW-1:0] nq, dq, nrem, drem;
  logic [CW-1:0] cnt;

  logic [SW-1:0] trial_n, trial_d;
  logic [NXW-1:0] num_ext, num_sgn;
  logic [DXW-1:0] den_ext;
  rar_pkg::out_t res_next;

  assign pop = (state == B_IDLE) && !empty;

  assign trial_n = {nrem[SW-2:0], nq[SW-1]};
  assign trial_d = {drem[SW-2:0], dq[SW-1]};

  assign num_ext = NXW'(nq);
  assign num_sgn = job.neg ? (~num_ext + 1'b1) : num_ext;
  assign den_ext = DXW'(dq);

  always_comb begin
    if (job.status != rar_pkg::STAT_OK) begin
      res_next.res_num = '0;
      res_next.res_den = '0;
      res_next.status  = job.status;
    end else if (job.num_mag == '0) begin
      res_next.res_num = '0;
      res_next.res_den = rar_pkg::RES_DEN_W'(1);
      res_next.status  = rar_pkg::STAT_OK;
    end else begin
      res_next.res_num = num_sgn[rar_pkg::RES_NUM_W-1:0];
      res_next.res_den = den_ext[rar_pkg::RES_DEN_W-1:0];
      res_next.status  = rar_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
    end else begin
      if ((state == B_DONE) && (!res_valid || !res_stall)) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!empty) begin
            job <= pop_data;
            u   <= pop_data.num_mag;
            v   <= pop_data.den_mag;
            k   <= '0;
            if ((pop_data.status != rar_pkg::STAT_OK) || (pop_data.num_mag == '0)) begin
              state <= B_DONE;
            end else begin
              state <= B_GCD;
            end
          end
        end
        B_GCD: begin
          // Stein step; v never reaches zero, gcd is v << k once u is zero
          if (u == '0) begin
            state <= B_SCALE;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 1'b1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u >= v) begin
            u <= (u - v) >> 1;
          end else begin
            v <= (v - u) >> 1;
          end
        end
        B_SCALE: begin
          g     <= v << k;
          nq    <= job.num_mag;
          dq    <= job.den_mag;
          nrem  <= '0;
          drem  <= '0;
          cnt   <= CW'(SW - 1);
          state <= B_DIV;
        end
        B_DIV: begin
          // restoring division, one quotient bit per cycle for both values
          if (trial_n >= g) begin
            nrem <= trial_n - g;
            nq   <= {nq[SW-2:0], 1'b1};
          end else begin
            nrem <= trial_n;
            nq   <= {nq[SW-2:0], 1'b0};
          end
          if (trial_d >= g) begin
            drem <= trial_d - g;
            dq   <= {dq[SW-2:0], 1'b1};
          end else begin
            drem <= trial_d;
            dq   <= {dq[SW-2:0], 1'b0};
          end
          if (cnt == '0) begin
            state <= B_DONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        B_DONE: begin
          if (!res_valid || !res_stall) begin
            res_data <= res_next;
            state    <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_div_done, (state == B_DIV && cnt == '0) |=> (state == B_DONE), "divider overran")
  `ASSERT_CLK(a_err_den, (res_valid && res_data.status != rar_pkg::STAT_OK) |-> (res_data.res_den == '0), "error result with nonzero denominator")

endmodule

[test/rar_result_checker.sv]
// Result checker for the rational arithmetic unit: predicts each request and compares results.
`timescale 1ns / 1ps

module rar_result_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  rar_pkg::in_t  req_data,
  input  logic          res_valid,
  input  logic          res_stall,
  input  rar_pkg::out_t res_data,
  output int            mismatch_count,
  output int            pending_count
);

  rar_pkg::out_t expected_results[$];
  rar_pkg::out_t want;
  int            result_index = 0;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  // Exact rational result of one request, reduced, sign in the numerator.
  function automatic rar_pkg::out_t reduce_fraction_result(rar_pkg::in_t rq);
    rar_pkg::out_t   r;
    longint          an, ad, bn, bd, num, den;
    longint unsigned nmag, dmag, x, y, tmp;
    logic            neg;
    logic [63:0]     nout;
    begin
      r  = '0;
      an = longint'(rq.a_num);
      ad = longint'(rq.a_den);
      bn = longint'(rq.b_num);
      bd = longint'(rq.b_den);
      if (ad == 0 || bd == 0) begin
        r.status = rar_pkg::STAT_ZERO_DEN;
        return r;
      end
      if (rq.command == rar_pkg::CMD_DIV && bn == 0) begin
        r.status = rar_pkg::STAT_DIV_ZERO;
        return r;
      end
      case (rq.command)
        rar_pkg::CMD_ADD: begin
          num = an * bd + bn * ad;
          den = ad * bd;
        end
        rar_pkg::CMD_SUB: begin
          num = an * bd - bn * ad;
          den = ad * bd;
        end
        rar_pkg::CMD_MUL: begin
          num = an * bn;
          den = ad * bd;
        end
        default: begin
          num = an * bd;
          den = ad * bn;
        end
      endcase
      r.status = rar_pkg::STAT_OK;
      if (num == 0) begin
        r.res_den = rar_pkg::RES_DEN_W'(1);
        return r;
      end
      neg  = (num < 0) != (den < 0);
      nmag = (num < 0) ? -num : num;
      dmag = (den < 0) ? -den : den;
      x = nmag;
      y = dmag;
      while (y != 0) begin
        tmp = x % y;
        x   = y;
        y   = tmp;
      end
      nmag = nmag / x;
      dmag = dmag / x;
      nout = neg ? (64'd0 - nmag) : nmag;
      r.res_num = nout[rar_pkg::RES_NUM_W-1:0];
      r.res_den = dmag[rar_pkg::RES_DEN_W-1:0];
      return r;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    begin
      mismatch_count = mismatch_count + 1;
      $display("[%0t] result %0d mismatch: %s", $time, result_index, msg);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      // Results are checked before the new request is queued, so a result
      // can never be matched against a request taken at the same edge.
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("no request pending, got %0d/%0d status %0d",
                                    res_data.res_num, res_data.res_den, res_data.status));
        end else begin
          want = expected_results.pop_front();
          if (res_data.res_num !== want.res_num)
            report_mismatch($sformatf("res_num got %0d exp %0d",
                                      res_data.res_num, want.res_num));
          if (res_data.res_den !== want.res_den)
            report_mismatch($sformatf("res_den got %0d exp %0d",
                                      res_data.res_den, want.res_den));
          if (res_data.status !== want.status)
            report_mismatch($sformatf("status got %0d exp %0d",
                                      res_data.status, want.status));
        end
        result_index = result_index + 1;
      end
      if (req_valid && !req_stall)
        expected_results.push_back(reduce_fraction_result(req_data));
      pending_count <= expected_results.size();
    end
  end

endmodule

[test/tb_rational_arith_reduce_unit.sv]
// Testbench top for the rational arithmetic unit: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_rational_arith_reduce_unit;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES    = 150;
  localparam int RESET_CYCLES    = 12;
  localparam int ITEMS_PER_PHASE = 450;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  rar_pkg::in_t  req_data  = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  rar_pkg::out_t res_data;

  int    sender_idle_pct   = 37;
  int    receiver_idle_pct = 81;
  int    cycle_count       = 0;
  int    mismatch_count;
  int    pending_count;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rational_arith_reduce_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data)
  );

  rar_result_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_data      (req_data),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res_data      (res_data),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Hold one request until taken; valid only drops when a gap is drawn.
  task automatic send_request(input rar_pkg::in_t item);
    int gap;
    begin
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct)
        gap++;
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clk);
      while (req_stall) @(posedge clk);
    end
  endtask

  task automatic send_fractions(input logic [rar_pkg::CMD_W-1:0] cmd,
                                input int an, input int ad, input int bn, input int bd);
    rar_pkg::in_t item;
    begin
      item.command = cmd;
      item.a_num   = an[rar_pkg::OPERAND_W-1:0];
      item.a_den   = ad[rar_pkg::OPERAND_W-1:0];
      item.b_num   = bn[rar_pkg::OPERAND_W-1:0];
      item.b_den   = bd[rar_pkg::OPERAND_W-1:0];
      send_request(item);
    end
  endtask

  // Mix of full-range, small (lots of common factors), extreme and
  // power-of-two heavy operands.
  function automatic int random_operand();
    int v;
    begin
      case ($urandom_range(9))
        0, 1, 2, 3: v = int'($urandom_range(65535)) - 32768;
        4, 5, 6:    v = int'($urandom_range(40)) - 20;
        7: begin
          case ($urandom_range(4))
            0:       v = -32768;
            1:       v = 32767;
            2:       v = -1;
            3:       v = 1;
            default: v = 0;
          endcase
        end
        default: v = (int'($urandom_range(255)) - 128) <<< $urandom_range(8);
      endcase
      return v;
    end
  endfunction

  task automatic send_random_request();
    logic [rar_pkg::CMD_W-1:0] cmd;
    int an, ad, bn, bd;
    begin
      cmd = rar_pkg::CMD_W'($urandom_range(3));
      an  = random_operand();
      bn  = random_operand();
      ad  = random_operand();
      bd  = random_operand();
      // keep zero denominators rare but present
      if (ad == 0 && $urandom_range(3) != 0) ad = 1;
      if (bd == 0 && $urandom_range(3) != 0) bd = -1;
      if (cmd == rar_pkg::CMD_DIV && $urandom_range(15) == 0) bn = 0;
      send_fractions(cmd, an, ad, bn, bd);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed requests
    send_fractions(rar_pkg::CMD_ADD, 1, 2, 1, 3);
    send_fractions(rar_pkg::CMD_SUB, 1, 2, 1, 2);
    send_fractions(rar_pkg::CMD_MUL, -3, 4, 2, -3);
    send_fractions(rar_pkg::CMD_DIV, 5, 6, -10, 3);
    send_fractions(rar_pkg::CMD_ADD, 1, -2, 1, -3);
    send_fractions(rar_pkg::CMD_ADD, -32768, 32767, -32768, 32765);
    send_fractions(rar_pkg::CMD_SUB, 32767, 32766, -32768, 32765);
    send_fractions(rar_pkg::CMD_SUB, -32768, 1, 32767, 1);
    send_fractions(rar_pkg::CMD_MUL, -32768, -1, -32768, -1);
    send_fractions(rar_pkg::CMD_MUL, 32767, -32768, 32767, -32768);
    send_fractions(rar_pkg::CMD_DIV, 32767, -32768, -32768, 32767);
    send_fractions(rar_pkg::CMD_DIV, -32768, 1, -1, 32767);
    send_fractions(rar_pkg::CMD_ADD, -32768, -32768, -32768, -32768);
    send_fractions(rar_pkg::CMD_ADD, 1, 0, 1, 1);
    send_fractions(rar_pkg::CMD_MUL, 1, 1, 1, 0);
    // zero denominator wins over division by a zero fraction
    send_fractions(rar_pkg::CMD_DIV, 3, 0, 0, 5);
    send_fractions(rar_pkg::CMD_DIV, 3, 4, 0, 5);
    send_fractions(rar_pkg::CMD_DIV, 3, 4, 0, -1);
    send_fractions(rar_pkg::CMD_MUL, 0, 5, 7, 3);
    send_fractions(rar_pkg::CMD_DIV, 0, -7, 3, 5);
    send_fractions(rar_pkg::CMD_SUB, -32768, -32768, 1, 1);
    send_fractions(rar_pkg::CMD_ADD, 0, -32768, 0, 32767);

    repeat (ITEMS_PER_PHASE) send_random_request();

    sender_idle_pct   = 81;
    receiver_idle_pct = 37;
    repeat (ITEMS_PER_PHASE) send_random_request();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    repeat (ITEMS_PER_PHASE) send_random_request();

    req_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
